@@ src/deqs_pkg.sv @@
// ----------------------------------------------------------------------------
// deqs_pkg: shared types and codes
// Request and result words, cell control and the return-chain word.
// ----------------------------------------------------------------------------
`default_nettype none

package deqs_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 4;

  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [1:0] STAT_PUSH_FULL = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [DataW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_out;
    logic [1:0]              status;
    logic [PosW-1:0]         found_position;
    logic                    now_empty;
  } res_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_BACK,
    CELL_SHIFT_RIGHT,
    CELL_SHIFT_LEFT,
    CELL_POP_BACK,
    CELL_SEARCH,
    CELL_RET_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [DataW-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] data;
  } ret_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage : deqs_pkg

`default_nettype wire

@@ src/deqs_cell.sv @@
// ----------------------------------------------------------------------------
// deqs_cell: one queue slot
// Holds one entry and its valid bit, shifts with its neighbors, and drives
// a return word that moves one cell toward the front per cycle while the chain is shifted.
// ----------------------------------------------------------------------------
`default_nettype none

module deqs_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire deqs_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [deqs_pkg::DataW-1:0] prev_data_i,
  input  wire logic                       prev_valid_i,
  input  wire logic [deqs_pkg::DataW-1:0] next_data_i,
  input  wire logic                       next_valid_i,
  input  wire deqs_pkg::ret_t             next_ret_i,
  output logic [deqs_pkg::DataW-1:0]      data_o,
  output logic                            valid_o,
  output deqs_pkg::ret_t                  ret_o
);

  logic [deqs_pkg::DataW-1:0] data_q, data_d;
  logic                       valid_q, valid_d;
  deqs_pkg::ret_t             ret_q, ret_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    ret_d   = ret_q;
    case (ctrl_i.op)
      deqs_pkg::CELL_PUSH_BACK: begin
        if (!valid_q && prev_valid_i) begin
          data_d  = ctrl_i.key;
          valid_d = 1'b1;
        end
      end
      deqs_pkg::CELL_SHIFT_RIGHT: begin
        data_d  = prev_data_i;
        valid_d = prev_valid_i;
      end
      deqs_pkg::CELL_SHIFT_LEFT: begin
        data_d  = next_data_i;
        valid_d = next_valid_i;
      end
      deqs_pkg::CELL_POP_BACK: begin
        ret_d.hit  = valid_q && !next_valid_i;
        ret_d.data = data_q;
        if (valid_q && !next_valid_i) begin
          valid_d = 1'b0;
        end
      end
      deqs_pkg::CELL_SEARCH: begin
        ret_d.hit  = valid_q && (data_q == ctrl_i.key);
        ret_d.data = data_q;
      end
      deqs_pkg::CELL_RET_SHIFT: begin
        ret_d = next_ret_i;
      end
      default: begin
        ret_d = ret_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ret_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ret_q   <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign ret_o   = ret_q;

endmodule : deqs_cell

`default_nettype wire

@@ src/double_ended_queue_with_search.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_with_search: bounded deque of signed 32-bit words
// Push and pop at both ends, and search for the first matching entry.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_i and raise start; the word is taken at a clock edge where
//   start is high and busy is low. Every request gives one result word on
//   res_o, marked by done_o for exactly one cycle.
//   Push back, push front, pop front, and any pop or push that fails
//   complete without a scan: done_o rises the cycle after the request is taken,
//   and busy stays low, so these may follow each other in every cycle.
//   Pop back and search load a return word into every cell of the chain;
//   that word moves one cell toward the front per cycle, and the scan ends
//   when a hit reaches the front cell or, for a search, when the scan has
//   passed the last entry. busy is high until the result is shown.
//   Reset empties the queue at once; no clearing pass is run.
//   The receiver cannot stall: each result is valid for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire deqs_pkg::req_t  req_i,
  output logic                 busy,
  output logic                 done_o,
  output deqs_pkg::res_t       res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  deqs_pkg::state_e           state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [IdxW-1:0]            scan_q, scan_d;
  logic                       pop_q, pop_d;
  logic                       done_q, done_d;
  deqs_pkg::res_t             res_q, res_d;
  deqs_pkg::cell_ctrl_t       ctrl;

  logic [deqs_pkg::DataW-1:0] cell_data  [DEPTH];
  logic                       cell_valid [DEPTH];
  deqs_pkg::ret_t             cell_ret   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [deqs_pkg::DataW-1:0] prev_data, next_data;
    logic                       prev_valid, next_valid;
    deqs_pkg::ret_t             next_ret;

    if (i == 0) begin : g_first
      assign prev_data  = ctrl.key;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data  = '0;
      assign next_valid = 1'b0;
      assign next_ret   = '0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
      assign next_ret   = cell_ret[i+1];
    end

    deqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .next_ret_i   (next_ret),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .ret_o        (cell_ret[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    scan_d   = scan_q;
    pop_d    = pop_q;
    done_d   = 1'b0;
    res_d    = res_q;
    ctrl.op  = deqs_pkg::CELL_HOLD;
    ctrl.key = req_i.data_in;
    case (state_q)
      deqs_pkg::ST_IDLE: begin
        if (start) begin
          res_d  = '0;
          done_d = 1'b1;
          case (req_i.req_type)
            deqs_pkg::REQ_PUSH_BACK: begin
              if (count_q == CntW'(DEPTH)) begin
                res_d.status = deqs_pkg::STAT_PUSH_FULL;
              end else begin
                ctrl.op = deqs_pkg::CELL_PUSH_BACK;
                count_d = count_q + 1'b1;
              end
            end
            deqs_pkg::REQ_PUSH_FRONT: begin
              if (count_q == CntW'(DEPTH)) begin
                res_d.status = deqs_pkg::STAT_PUSH_FULL;
              end else begin
                ctrl.op = deqs_pkg::CELL_SHIFT_RIGHT;
                count_d = count_q + 1'b1;
              end
            end
            deqs_pkg::REQ_POP_FRONT: begin
              if (count_q == '0) begin
                res_d.status = deqs_pkg::STAT_POP_EMPTY;
              end else begin
                ctrl.op        = deqs_pkg::CELL_SHIFT_LEFT;
                count_d        = count_q - 1'b1;
                res_d.data_out = cell_data[0];
              end
            end
            deqs_pkg::REQ_POP_BACK: begin
              if (count_q == '0) begin
                res_d.status = deqs_pkg::STAT_POP_EMPTY;
              end else begin
                ctrl.op = deqs_pkg::CELL_POP_BACK;
                count_d = count_q - 1'b1;
                scan_d  = '0;
                pop_d   = 1'b1;
                done_d  = 1'b0;
                state_d = deqs_pkg::ST_SCAN;
              end
            end
            deqs_pkg::REQ_SEARCH: begin
              ctrl.op = deqs_pkg::CELL_SEARCH;
              scan_d  = '0;
              pop_d   = 1'b0;
              done_d  = 1'b0;
              state_d = deqs_pkg::ST_SCAN;
            end
            default: begin
              res_d.status = deqs_pkg::STAT_OK;
            end
          endcase
        end
      end
      deqs_pkg::ST_SCAN: begin
        if (cell_ret[0].hit) begin
          done_d        = 1'b1;
          res_d         = '0;
          state_d       = deqs_pkg::ST_IDLE;
          if (pop_q) begin
            res_d.data_out = cell_ret[0].data;
          end else begin
            res_d.found_position = deqs_pkg::PosW'(scan_q);
          end
        end else if (!pop_q && ((CntW'(scan_q) + CntW'(1)) >= count_q)) begin
          done_d       = 1'b1;
          res_d        = '0;
          res_d.status = deqs_pkg::STAT_NOT_FOUND;
          state_d      = deqs_pkg::ST_IDLE;
        end else begin
          ctrl.op = deqs_pkg::CELL_RET_SHIFT;
          scan_d  = scan_q + 1'b1;
        end
      end
      default: begin
        state_d = deqs_pkg::ST_IDLE;
      end
    endcase
    res_d.now_empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deqs_pkg::ST_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      pop_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      pop_q   <= pop_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy   = (state_q != deqs_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule : double_ended_queue_with_search

`default_nettype wire
